>>> rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// Package for the buddy page allocator: field widths, types, action,
// status and register codes. No dependencies.
package bpa_pkg;

    localparam int ACTION_W   = 2;
    localparam int REQ_W      = 11;
    localparam int PAGE_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int LEVEL_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int LCOUNT_W   = 4;
    localparam int NPAGES_W   = 11;

    typedef logic [ACTION_W-1:0]   t_action;
    typedef logic [REQ_W-1:0]      t_req;
    typedef logic [PAGE_W-1:0]     t_page;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [LEVEL_W-1:0]    t_level;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_action ACT_ALLOC = 2'd0;
    localparam t_action ACT_FREE  = 2'd1;
    localparam t_action ACT_INIT  = 2'd2;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_SIZE  = 3'd1;
    localparam t_status ST_NO_BLOCK  = 3'd2;
    localparam t_status ST_BAD_PAGE  = 3'd3;
    localparam t_status ST_NOT_ALLOC = 3'd4;

    localparam t_cfg_idx REG_LEVEL_COUNT  = 1'd0;
    localparam t_cfg_idx REG_PAGES_IN_USE = 1'd1;

    localparam logic [LCOUNT_W-1:0] RESET_LEVEL_COUNT  = 4'd11;
    localparam logic [NPAGES_W-1:0] RESET_PAGES_IN_USE = 11'd1024;

    // Bit position of a one-hot request; caller checks one-hotness.
    function automatic t_level req_log2(input t_req req);
        t_level res;
        res = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (req[i]) begin
                res = LEVEL_W'(i);
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/bpa_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the buddy page allocator: request, response and
// configuration write. Depends on bpa_pkg.
interface bpa_req_if;
    logic              valid;
    logic              ready;
    bpa_pkg::t_action  action;
    bpa_pkg::t_req     request_pages;
    bpa_pkg::t_page    page_index;
    modport source(output valid, action, request_pages, page_index, input ready);
    modport sink(input valid, action, request_pages, page_index, output ready);
endinterface

interface bpa_rsp_if;
    logic              valid;
    logic              ready;
    bpa_pkg::t_status  status;
    bpa_pkg::t_page    block_page;
    bpa_pkg::t_level   block_level;
    modport source(output valid, status, block_page, block_level, input ready);
    modport sink(input valid, status, block_page, block_level, output ready);
endinterface

interface bpa_cfg_if;
    logic               valid;
    logic               ready;
    bpa_pkg::t_cfg_idx  index;
    bpa_pkg::t_cfg_data data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/bpa_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/buddy_page_allocator_top.sv
`timescale 1ns / 1ps
// Buddy page allocator top level: sequencer, free-list heads and counts,
// page table RAM. Depends on bpa_pkg, bpa_if and bpa_ram.
//
//  channel  dir   transfer when          payload
//  i_req    in    valid & ready          action, request_pages, page_index
//  o_rsp    out   valid & ready          status, block_page, block_level
//  i_cfg    in    valid & ready (always) index, data
//
//  One item at a time. Allocate: decode, scan up one level at a time, unlink
//  the block found, push each split-off upper half, record its level. Free:
//  read and clear the page record, then per merge read and unlink the buddy,
//  and push the final block. Init: clear the table (one RAM write port, one
//  entry a cycle), then step down the levels and push each block laid out.
//  Reset (synchronous, active low) empties all lists; no clearing pass is
//  needed since no page is valid until init. A stalled result holds in the
//  output register while the next request is already taken.
module buddy_page_allocator_top #(
    parameter int MAX_PAGES  = 1024,
    parameter int MAX_LEVELS = 11
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp,
    bpa_cfg_if.sink   i_cfg
);
    import bpa_pkg::*;

    // Widths: page address, link (page plus null flag), level, count.
    localparam int PW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int LW   = PW + 1;
    localparam int LVW  = $clog2(MAX_LEVELS + 1);
    localparam int LIW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNTW = PW + 1;
    localparam int SZW  = (MAX_LEVELS > CNTW) ? MAX_LEVELS : CNTW;

    // Page table entry: next, prev, alloc valid, alloc level, free mark,
    // free level.
    localparam int F_NEXT = 0;
    localparam int F_PREV = LW;
    localparam int F_AV   = 2 * LW;
    localparam int F_AL   = F_AV + 1;
    localparam int F_FM   = F_AL + LVW;
    localparam int F_FL   = F_FM + 1;
    localparam int EW     = F_FL + LVW;

    localparam logic [LW-1:0]  LINK_NULL = LW'(1) << PW;
    localparam logic [LVW-1:0] LV_RESET  = (MAX_LEVELS < 11) ? LVW'(MAX_LEVELS) : LVW'(11);

    // Sequencer states.
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_DONE    = 5'd2;
    localparam logic [4:0] S_A_SCAN  = 5'd3;
    localparam logic [4:0] S_A_SPLIT = 5'd4;
    localparam logic [4:0] S_A_MRD   = 5'd5;
    localparam logic [4:0] S_A_MWR   = 5'd6;
    localparam logic [4:0] S_F_RD    = 5'd7;
    localparam logic [4:0] S_F_CHK   = 5'd8;
    localparam logic [4:0] S_F_M     = 5'd9;
    localparam logic [4:0] S_F_M2    = 5'd10;
    localparam logic [4:0] S_F_MU    = 5'd11;
    localparam logic [4:0] S_F_END   = 5'd12;
    localparam logic [4:0] S_CLR     = 5'd13;
    localparam logic [4:0] S_I_D     = 5'd14;
    localparam logic [4:0] S_R0      = 5'd15;
    localparam logic [4:0] S_R1      = 5'd16;
    localparam logic [4:0] S_R2      = 5'd17;
    localparam logic [4:0] S_R3      = 5'd18;
    localparam logic [4:0] S_R4      = 5'd19;
    localparam logic [4:0] S_R5      = 5'd20;
    localparam logic [4:0] S_P0      = 5'd21;
    localparam logic [4:0] S_P1      = 5'd22;
    localparam logic [4:0] S_P2      = 5'd23;
    localparam logic [4:0] S_P3      = 5'd24;

    // Control registers.
    logic [4:0]          r_state, n_state;
    logic [4:0]          r_ret, n_ret;
    logic [LW-1:0]       r_head [MAX_LEVELS];
    logic [LW-1:0]       n_head [MAX_LEVELS];
    logic [CNTW-1:0]     r_len [MAX_LEVELS];
    logic [CNTW-1:0]     n_len [MAX_LEVELS];
    logic [LVW-1:0]      r_live_lv, n_live_lv;
    logic [CNTW-1:0]     r_live_pg, n_live_pg;
    logic [LCOUNT_W-1:0] r_lcount;
    logic [NPAGES_W-1:0] r_npages;
    logic                r_ovalid;

    // Working registers.
    t_action         r_act;
    t_req            r_req;
    t_page           r_pidx;
    logic [LVW-1:0]  r_want, n_want;
    logic [LVW-1:0]  r_lvl, n_lvl;
    logic [PW-1:0]   r_pg, n_pg;
    logic [PW-1:0]   r_pn, n_pn;
    logic [PW-1:0]   r_blk, n_blk;
    logic [LW-1:0]   r_p, n_p;
    logic [LW-1:0]   r_n, n_n;
    logic [LW-1:0]   r_h, n_h;
    logic [PW-1:0]   r_clr, n_clr;
    logic [CNTW-1:0] r_at, n_at;
    logic [CNTW-1:0] r_left, n_left;
    t_status         r_st, n_st;
    t_page           r_bp, n_bp;
    t_level          r_bl, n_bl;
    t_status         r_o_st;
    t_page           r_o_pg;
    t_level          r_o_lv;

    // RAM port.
    logic          mem_we, mem_re;
    logic [PW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    logic [LW-1:0]  rd_next, rd_prev;
    logic           rd_av, rd_fm;
    logic [LVW-1:0] rd_al, rd_fl;

    logic              in_take, out_load;
    logic [LIW-1:0]    lidx;
    logic [SZW-1:0]    size_lvl, nb_w;
    logic [LVW-1:0]    lvl_dn;
    t_level            want_raw;
    logic [LVW-1:0]    lv_clamp;
    logic [CNTW-1:0]   pg_clamp;

    bpa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PAGES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_next = mem_rdata[F_NEXT +: LW];
    assign rd_prev = mem_rdata[F_PREV +: LW];
    assign rd_av   = mem_rdata[F_AV];
    assign rd_al   = mem_rdata[F_AL +: LVW];
    assign rd_fm   = mem_rdata[F_FM];
    assign rd_fl   = mem_rdata[F_FL +: LVW];

    assign i_req.ready = (r_state == S_IDLE);
    assign in_take     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_o_st;
    assign o_rsp.block_page  = r_o_pg;
    assign o_rsp.block_level = r_o_lv;

    assign lidx     = r_lvl[LIW-1:0];
    assign size_lvl = SZW'(1) << r_lvl;
    assign nb_w     = SZW'(r_pn) ^ size_lvl;
    assign lvl_dn   = r_lvl - LVW'(1);
    assign want_raw = req_log2(r_req);

    // Init clamps the registers into range.
    assign lv_clamp = (r_lcount == '0) ? LVW'(1) :
                      (32'(r_lcount) > MAX_LEVELS) ? LVW'(MAX_LEVELS) : LVW'(r_lcount);
    assign pg_clamp = (32'(r_npages) > MAX_PAGES) ? CNTW'(MAX_PAGES) : CNTW'(r_npages);

    // Result leaves for the output register when it is empty or draining.
    assign out_load = (r_state == S_DONE) && (!r_ovalid || o_rsp.ready);

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_head    = r_head;
        n_len     = r_len;
        n_live_lv = r_live_lv;
        n_live_pg = r_live_pg;
        n_want    = r_want;
        n_lvl     = r_lvl;
        n_pg      = r_pg;
        n_pn      = r_pn;
        n_blk     = r_blk;
        n_p       = r_p;
        n_n       = r_n;
        n_h       = r_h;
        n_clr     = r_clr;
        n_at      = r_at;
        n_left    = r_left;
        n_st      = r_st;
        n_bp      = r_bp;
        n_bl      = r_bl;
        mem_we    = 1'b0;
        mem_waddr = r_pg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_pg;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_START;
                end
            end

            // Decode the request; default result is all zero.
            S_START: begin
                n_st = ST_OK;
                n_bp = '0;
                n_bl = '0;
                case (r_act)
                    ACT_ALLOC: begin
                        if (r_req == '0 || (r_req & (r_req - REQ_W'(1))) != '0) begin
                            n_st    = ST_BAD_SIZE;
                            n_state = S_DONE;
                        end else if (32'(want_raw) >= 32'(r_live_lv)) begin
                            n_st    = ST_NO_BLOCK;
                            n_state = S_DONE;
                        end else begin
                            n_want  = LVW'(want_raw);
                            n_lvl   = LVW'(want_raw);
                            n_state = S_A_SCAN;
                        end
                    end
                    ACT_FREE: begin
                        if (32'(r_pidx) >= 32'(r_live_pg)) begin
                            n_st    = ST_BAD_PAGE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end
                    ACT_INIT: begin
                        n_live_lv = lv_clamp;
                        n_live_pg = pg_clamp;
                        for (int i = 0; i < MAX_LEVELS; i++) begin
                            n_head[i] = LINK_NULL;
                            n_len[i]  = '0;
                        end
                        n_clr   = '0;
                        n_state = S_CLR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Find the smallest non-empty level at or above the request.
            S_A_SCAN: begin
                if (r_lvl >= r_live_lv) begin
                    n_st    = ST_NO_BLOCK;
                    n_state = S_DONE;
                end else if (r_len[lidx] == '0) begin
                    n_lvl = r_lvl + LVW'(1);
                end else if (r_head[lidx][PW]) begin
                    n_st    = ST_NO_BLOCK;
                    n_state = S_DONE;
                end else begin
                    n_blk   = r_head[lidx][PW-1:0];
                    n_pg    = r_head[lidx][PW-1:0];
                    n_ret   = S_A_SPLIT;
                    n_state = S_R0;
                end
            end

            // Push the upper half at each level down to the request.
            S_A_SPLIT: begin
                if (r_lvl > r_want) begin
                    n_lvl   = lvl_dn;
                    n_pg    = r_blk + PW'(SZW'(1) << lvl_dn);
                    n_ret   = S_A_SPLIT;
                    n_state = S_P0;
                end else begin
                    n_state = S_A_MRD;
                end
            end

            S_A_MRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_blk;
                n_state   = S_A_MWR;
            end

            // Record the level of the block handed out.
            S_A_MWR: begin
                mem_we                 = 1'b1;
                mem_waddr              = r_blk;
                mem_wdata[F_AV]        = 1'b1;
                mem_wdata[F_AL +: LVW] = r_want;
                n_bp    = PAGE_W'(r_blk);
                n_bl    = LEVEL_W'(r_want);
                n_state = S_DONE;
            end

            S_F_RD: begin
                mem_re    = 1'b1;
                mem_raddr = PW'(r_pidx);
                n_state   = S_F_CHK;
            end

            // Check the record of the page and clear it.
            S_F_CHK: begin
                if (!rd_av || rd_al >= r_live_lv) begin
                    n_st    = ST_NOT_ALLOC;
                    n_state = S_DONE;
                end else begin
                    mem_we          = 1'b1;
                    mem_waddr       = PW'(r_pidx);
                    mem_wdata[F_AV] = 1'b0;
                    n_lvl           = rd_al;
                    n_pn            = PW'(r_pidx);
                    n_state         = S_F_M;
                end
            end

            // Try to merge with the buddy at the current level.
            S_F_M: begin
                if (32'(r_lvl) + 32'd1 < 32'(r_live_lv) &&
                    (SZW + 1)'(nb_w) + (SZW + 1)'(size_lvl) <= (SZW + 1)'(r_live_pg)) begin
                    mem_re    = 1'b1;
                    mem_raddr = PW'(nb_w);
                    n_pg      = PW'(nb_w);
                    n_state   = S_F_M2;
                end else begin
                    n_pg    = r_pn;
                    n_ret   = S_F_END;
                    n_state = S_P0;
                end
            end

            S_F_M2: begin
                if (rd_av || !rd_fm || rd_fl != r_lvl) begin
                    n_pg    = r_pn;
                    n_ret   = S_F_END;
                    n_state = S_P0;
                end else begin
                    if (r_pg < r_pn) begin
                        n_pn = r_pg;
                    end
                    n_ret   = S_F_MU;
                    n_state = S_R0;
                end
            end

            S_F_MU: begin
                n_lvl   = r_lvl + LVW'(1);
                n_state = S_F_M;
            end

            S_F_END: begin
                n_bp    = r_pidx;
                n_bl    = LEVEL_W'(r_lvl);
                n_state = S_DONE;
            end

            // Clear every page entry, one a cycle.
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + PW'(1);
                if (r_clr == PW'(MAX_PAGES - 1)) begin
                    n_lvl   = r_live_lv - LVW'(1);
                    n_at    = '0;
                    n_left  = r_live_pg;
                    n_state = S_I_D;
                end
            end

            // Lay out top-level blocks, then at most one per lower level.
            S_I_D: begin
                if (SZW'(r_left) >= size_lvl) begin
                    n_pg    = PW'(r_at);
                    n_at    = r_at + CNTW'(size_lvl);
                    n_left  = r_left - CNTW'(size_lvl);
                    n_ret   = S_I_D;
                    n_state = S_P0;
                end else if (r_lvl == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl = lvl_dn;
                end
            end

            // Unlink r_pg from the list of level r_lvl.
            S_R0: begin
                mem_re  = 1'b1;
                n_state = S_R1;
            end

            S_R1: begin
                mem_we          = 1'b1;
                mem_wdata[F_FM] = 1'b0;
                n_p             = rd_prev;
                n_n             = rd_next;
                if (r_len[lidx] != '0) begin
                    n_len[lidx] = r_len[lidx] - CNTW'(1);
                end
                if (rd_prev[PW]) begin
                    n_head[lidx] = rd_next;
                    n_state      = rd_next[PW] ? r_ret : S_R4;
                end else begin
                    n_state = S_R2;
                end
            end

            S_R2: begin
                mem_re    = 1'b1;
                mem_raddr = r_p[PW-1:0];
                n_state   = S_R3;
            end

            S_R3: begin
                mem_we                 = 1'b1;
                mem_waddr              = r_p[PW-1:0];
                mem_wdata[F_NEXT +: LW] = r_n;
                n_state                = r_n[PW] ? r_ret : S_R4;
            end

            S_R4: begin
                mem_re    = 1'b1;
                mem_raddr = r_n[PW-1:0];
                n_state   = S_R5;
            end

            S_R5: begin
                mem_we                 = 1'b1;
                mem_waddr              = r_n[PW-1:0];
                mem_wdata[F_PREV +: LW] = r_p;
                n_state                = r_ret;
            end

            // Push r_pg onto the head of the list of level r_lvl.
            S_P0: begin
                mem_re  = 1'b1;
                n_h     = r_head[lidx];
                n_state = S_P1;
            end

            S_P1: begin
                mem_we                  = 1'b1;
                mem_wdata[F_NEXT +: LW] = r_h;
                mem_wdata[F_PREV +: LW] = LINK_NULL;
                mem_wdata[F_FM]         = 1'b1;
                mem_wdata[F_FL +: LVW]  = r_lvl;
                n_head[lidx]            = LW'(r_pg);
                n_len[lidx]             = r_len[lidx] + CNTW'(1);
                n_state                 = r_h[PW] ? r_ret : S_P2;
            end

            S_P2: begin
                mem_re    = 1'b1;
                mem_raddr = r_h[PW-1:0];
                n_state   = S_P3;
            end

            S_P3: begin
                mem_we                  = 1'b1;
                mem_waddr               = r_h[PW-1:0];
                mem_wdata[F_PREV +: LW] = LW'(r_pg);
                n_state                 = r_ret;
            end

            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_live_lv <= LV_RESET;
            r_live_pg <= '0;
            r_lcount  <= RESET_LEVEL_COUNT;
            r_npages  <= RESET_PAGES_IN_USE;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i] <= LINK_NULL;
                r_len[i]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_live_lv <= n_live_lv;
            r_live_pg <= n_live_pg;
            r_head    <= n_head;
            r_len     <= n_len;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_LEVEL_COUNT:  r_lcount <= LCOUNT_W'(i_cfg.data);
                    REG_PAGES_IN_USE: r_npages <= NPAGES_W'(i_cfg.data);
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_act  <= i_req.action;
            r_req  <= i_req.request_pages;
            r_pidx <= i_req.page_index;
        end
        r_want <= n_want;
        r_lvl  <= n_lvl;
        r_pg   <= n_pg;
        r_pn   <= n_pn;
        r_blk  <= n_blk;
        r_p    <= n_p;
        r_n    <= n_n;
        r_h    <= n_h;
        r_clr  <= n_clr;
        r_at   <= n_at;
        r_left <= n_left;
        r_st   <= n_st;
        r_bp   <= n_bp;
        r_bl   <= n_bl;
        if (out_load) begin
            r_o_st <= r_st;
            r_o_pg <= r_bp;
            r_o_lv <= r_bl;
        end
    end

    // The sequencer never reads and writes one entry in the same cycle.
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re && mem_waddr == mem_raddr))
        else $error("page RAM read and write collide");

    // Error results carry zero page and level.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_st != ST_OK) |-> (r_o_pg == '0 && r_o_lv == '0))
        else $error("error result with nonzero fields");

    // An accepted request starts work on the next cycle.
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_START))
        else $error("accepted request not started");

    // Working level never passes MAX_LEVELS while a walk is active.
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_START && r_state != S_CLR &&
         r_state != S_DONE) |->
            (32'(r_lvl) <= MAX_LEVELS))
        else $error("level out of range");

    // Results leave only from the done state.
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done");

endmodule

>>> bench/buddy_page_allocator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for buddy_page_allocator_top: a page-accurate allocator model
// predicts every response, directed and random traffic run under random stalls.
// Depends on bpa_pkg, bpa_if and the allocator RTL.
module buddy_page_allocator_top_tb;
    import bpa_pkg::*;

    localparam int NPAGES      = 1024;
    localparam int NLEVELS     = 11;
    localparam int IDLE_PCT    = 28;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        t_status status;
        t_page   page;
        t_level  level;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpa_req_if req_ch();
    bpa_rsp_if rsp_ch();
    bpa_cfg_if cfg_ch();

    buddy_page_allocator_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // Allocator model state: page tables, free lists and latched settings.
    bit          used_mark[NPAGES];
    t_level      used_level[NPAGES];
    bit          free_mark[NPAGES];
    t_level      free_level[NPAGES];
    logic [10:0] next_pg[NPAGES];
    logic [10:0] prev_pg[NPAGES];
    logic [10:0] head_pg[NLEVELS];
    int unsigned list_len[NLEVELS];
    logic [LCOUNT_W-1:0] level_count_reg = RESET_LEVEL_COUNT;
    logic [NPAGES_W-1:0] pages_reg       = RESET_PAGES_IN_USE;
    int unsigned live_levels = NLEVELS;
    int unsigned live_pages  = 0;

    t_rsp   pending_rsp_q[$];
    t_page  held_blocks_q[$];
    int     fail_count = 0;
    bit     quiet = 1'b0;
    int     hold_ask = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     stall_cycles = 0;

    function automatic void push_free(int lvl, int page);
        logic [10:0] h;
        h = head_pg[lvl];
        next_pg[page] = h;
        prev_pg[page] = 11'(NPAGES);
        if (h < NPAGES) prev_pg[h] = 11'(page);
        head_pg[lvl] = 11'(page);
        list_len[lvl]++;
        free_level[page] = t_level'(lvl);
        free_mark[page] = 1'b1;
    endfunction

    function automatic void unlink_free(int page);
        int lvl;
        logic [10:0] p, n;
        lvl = free_level[page];
        p = prev_pg[page];
        n = next_pg[page];
        if (lvl >= NLEVELS) return;
        if (p < NPAGES) next_pg[p] = n;
        else head_pg[lvl] = n;
        if (n < NPAGES) prev_pg[n] = p;
        if (list_len[lvl] > 0) list_len[lvl]--;
        free_mark[page] = 1'b0;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < NPAGES; i++) begin
            used_mark[i] = 1'b0;
            used_level[i] = '0;
            free_mark[i] = 1'b0;
            free_level[i] = '0;
            next_pg[i] = 11'(NPAGES);
            prev_pg[i] = 11'(NPAGES);
        end
        for (int i = 0; i < NLEVELS; i++) begin
            head_pg[i] = 11'(NPAGES);
            list_len[i] = 0;
        end
    endfunction

    // Carve the page range into top-level blocks, then one block per lower level.
    function automatic void build_lists();
        int lv, pg, top, left, at;
        lv = level_count_reg;
        pg = pages_reg;
        at = 0;
        if (lv < 1) lv = 1;
        if (lv > NLEVELS) lv = NLEVELS;
        if (pg > NPAGES) pg = NPAGES;
        clear_model();
        live_levels = lv;
        live_pages = pg;
        top = lv - 1;
        left = pg;
        for (int k = left >> top; k > 0; k--) begin
            push_free(top, at);
            at += 1 << top;
            left -= 1 << top;
        end
        while (top > 0) begin
            top--;
            if (left >= (1 << top)) begin
                push_free(top, at);
                at += 1 << top;
                left -= 1 << top;
            end
        end
    endfunction

    function automatic t_rsp predict_allocator(t_action act, t_req req, t_page pidx);
        t_rsp res;
        int want, lvl, blk, nb, pn;
        res = '0;
        case (act)
            ACT_ALLOC: begin
                if (req == '0 || (req & (req - 1'b1)) != '0) begin
                    res.status = ST_BAD_SIZE;
                end else begin
                    want = 0;
                    while ((1 << want) != req) want++;
                    lvl = want;
                    while (lvl < live_levels && list_len[lvl] == 0) lvl++;
                    if (lvl >= live_levels || head_pg[lvl] >= NPAGES) begin
                        res.status = ST_NO_BLOCK;
                    end else begin
                        blk = head_pg[lvl];
                        unlink_free(blk);
                        // Push the upper halves split off on the way down.
                        while (lvl > want) begin
                            lvl--;
                            push_free(lvl, blk + (1 << lvl));
                        end
                        used_mark[blk] = 1'b1;
                        used_level[blk] = t_level'(want);
                        res.page = t_page'(blk);
                        res.level = t_level'(want);
                    end
                end
            end
            ACT_FREE: begin
                if (pidx >= live_pages) begin
                    res.status = ST_BAD_PAGE;
                end else if (!used_mark[pidx] || used_level[pidx] >= live_levels) begin
                    res.status = ST_NOT_ALLOC;
                end else begin
                    lvl = used_level[pidx];
                    pn = pidx;
                    used_mark[pidx] = 1'b0;
                    // Merge with equal-level free buddies, never past the top level.
                    while (lvl + 1 < live_levels) begin
                        nb = pn ^ (1 << lvl);
                        if (nb + (1 << lvl) > live_pages || nb >= NPAGES) break;
                        if (used_mark[nb]) break;
                        if (!free_mark[nb] || free_level[nb] != lvl) break;
                        unlink_free(nb);
                        if (nb < pn) pn = nb;
                        lvl++;
                    end
                    push_free(lvl, pn);
                    res.page = pidx;
                    res.level = t_level'(lvl);
                end
            end
            ACT_INIT: build_lists();
            default: ;
        endcase
        return res;
    endfunction

    // Offer one request, hold it until the transfer, then record the expected response.
    task automatic send_item(t_action act, t_req req, t_page pidx);
        t_rsp res;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.request_pages <= req;
        req_ch.page_index <= pidx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        res = predict_allocator(act, req, pidx);
        pending_rsp_q.push_back(res);
        if (act == ACT_INIT) begin
            held_blocks_q.delete();
        end else if (act == ACT_ALLOC && res.status == ST_OK) begin
            held_blocks_q.push_back(res.page);
        end else if (act == ACT_FREE && res.status == ST_OK) begin
            foreach (held_blocks_q[i]) begin
                if (held_blocks_q[i] == pidx) begin
                    held_blocks_q.delete(i);
                    break;
                end
            end
        end
    endtask

    // Drain all responses, then let the sequencer settle before touching registers.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == REG_LEVEL_COUNT) level_count_reg = value[LCOUNT_W-1:0];
        else pages_reg = value[NPAGES_W-1:0];
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int lc, int np);
        drain();
        write_reg(REG_LEVEL_COUNT, t_cfg_data'(lc));
        write_reg(REG_PAGES_IN_USE, t_cfg_data'(np));
        send_item(ACT_INIT, '0, '0);
    endtask

    task automatic test_before_init();
        send_item(ACT_ALLOC, 11'd1, '0);
        send_item(ACT_FREE, '0, '0);
        send_item(ACT_FREE, '0, 10'h3FF);
        send_item(2'd3, 11'h7FF, 10'h3FF);
    endtask

    task automatic test_sizes_and_errors();
        send_item(ACT_INIT, '0, '0);
        send_item(ACT_ALLOC, 11'd1024, '0);
        send_item(ACT_ALLOC, 11'd1, '0);
        send_item(ACT_FREE, '0, 10'd1);
        send_item(ACT_FREE, '0, 10'h3FF);
        send_item(ACT_FREE, '0, '0);
        send_item(ACT_FREE, '0, '0);
        send_item(ACT_ALLOC, 11'd0, '0);
        send_item(ACT_ALLOC, 11'd3, '0);
        send_item(ACT_ALLOC, 11'h7FF, '0);
        for (int k = 0; k < 10; k++) send_item(ACT_ALLOC, t_req'(1 << k), '0);
        send_item(2'd3, '0, '0);
    endtask

    // Clamped and extreme register settings; changes after init must not matter.
    task automatic test_register_extremes();
        configure(0, 2047);
        send_item(ACT_ALLOC, 11'd2, '0);
        send_item(ACT_ALLOC, 11'd1, '0);
        configure(15, 0);
        send_item(ACT_ALLOC, 11'd1, '0);
        send_item(ACT_FREE, '0, '0);
        configure(4, 13);
        drain();
        write_reg(REG_PAGES_IN_USE, 11'd1024);
        send_item(ACT_ALLOC, 11'd1, '0);
        send_item(ACT_FREE, '0, 10'd13);
        send_item(ACT_ALLOC, 11'd8, '0);
        configure(1, 1);
        send_item(ACT_ALLOC, 11'd1, '0);
        send_item(ACT_FREE, '0, '0);
    endtask

    task automatic random_traffic(int count);
        int pick, idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(ACT_ALLOC, t_req'(1 << $urandom_range(0, 10)), t_page'($urandom));
                else
                    send_item(ACT_ALLOC, t_req'(1 << $urandom_range(0, 3)), t_page'($urandom));
            end else if (pick < 83 && held_blocks_q.size() != 0) begin
                idx = $urandom_range(0, held_blocks_q.size() - 1);
                send_item(ACT_FREE, t_req'($urandom), held_blocks_q[idx]);
            end else if (pick < 98) begin
                send_item(t_action'($urandom), t_req'($urandom), t_page'($urandom));
            end else begin
                send_item(ACT_INIT, t_req'($urandom), t_page'($urandom));
            end
        end
    endtask

    task automatic test_random_settings();
        configure(11, 1024);
        random_traffic(350);
        configure(5, 64);
        random_traffic(350);
        configure(3, 37);
        quiet = 1'b1;
        random_traffic(300);
        quiet = 1'b0;
        configure(7, 1000);
        random_traffic(350);
        configure(2, 5);
        random_traffic(200);
        configure($urandom_range(0, 15), $urandom_range(0, 2047));
        random_traffic(200);
    endtask

    // Stall the response side long enough that the request side backs up.
    task automatic test_backpressure();
        hold_ask++;
        random_traffic(30);
    endtask

    // Response side: random stalls, the requested hold-off, and the compare.
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp_q.size() == 0) begin
                $error("unexpected response: status %0d page %0d level %0d",
                       rsp_ch.status, rsp_ch.block_page, rsp_ch.block_level);
                fail_count++;
            end else begin
                want = pending_rsp_q.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.block_page !== want.page) begin
                    $error("block_page: expected %0d, got %0d", want.page, rsp_ch.block_page);
                    fail_count++;
                end
                if (rsp_ch.block_level !== want.level) begin
                    $error("block_level: expected %0d, got %0d", want.level,
                           rsp_ch.block_level);
                    fail_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer anywhere.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("buddy_page_allocator_top test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = ACT_ALLOC;
        req_ch.request_pages = '0;
        req_ch.page_index = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_LEVEL_COUNT;
        cfg_ch.data = '0;
        clear_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_init();
        test_sizes_and_errors();
        test_register_extremes();
        test_random_settings();
        test_backpressure();

        drain();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0)
            $display("buddy_page_allocator_top test passed");
        else
            $display("buddy_page_allocator_top test failed");
        $finish;
    end
endmodule

>>> files.f
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator_top.sv
bench/buddy_page_allocator_top_tb.sv
